FILE: sv/lfoc_pkg.sv
// lfoc_pkg: fixed widths and constants of the line fit outlier classifier
// no dependencies; used by lfoc_front, lfoc_back and line_fit_outlier_classifier
package lfoc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int FIT_W       = 40;
	localparam int LIMIT_W     = 32;
	localparam int INDEX_W     = 6;

	localparam logic [FIT_W-1:0]   FIT_POS_MAX   = 40'h7f_ffff_ffff;
	localparam logic [FIT_W-1:0]   FIT_NEG_MIN   = 40'h80_0000_0000;
	localparam logic [FIT_W-1:0]   RESID_MAX     = 40'hff_ffff_ffff;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 32'h0001_0000;

endpackage

FILE: sv/lfoc_queue.sv
// lfoc_queue: two-entry queue of block descriptors between front and back
// no package dependencies
module lfoc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output logic [W-1:0] head
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/lfoc_front.sv
// lfoc_front: accepts samples, writes them to the store and accumulates the sums
// depends on lfoc_pkg; pushes one descriptor per block into lfoc_queue
module lfoc_front #(
	parameter int DEPTH = 64
) (
	clk, arst_n, in_valid, in_stall, sample_value, block_end,
	q_full, push, push_data, wr
);
	localparam int SB     = lfoc_pkg::SAMPLE_BITS;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int XW     = $clog2(DEPTH);
	localparam int SYW    = SB + CW + 1;
	localparam int SXYW   = SB + 2 * CW + 1;
	localparam int SXW    = 2 * CW;
	localparam int SXXW   = 3 * CW;
	localparam int DESC_W = 1 + CW + SYW + SXYW + SXW + SXXW;
	localparam int WR_W   = 1 + XW + 1 + SB;

	typedef struct packed {
		logic                   bank;
		logic [CW-1:0]          n;
		logic signed [SYW-1:0]  sy;
		logic signed [SXYW-1:0] sxy;
		logic [SXW-1:0]         sx;
		logic [SXXW-1:0]        sxx;
	} desc_t;

	typedef struct packed {
		logic          we;
		logic [XW:0]   addr;
		logic [SB-1:0] data;
	} wr_t;

	input  logic                 clk;
	input  logic                 arst_n;
	input  logic                 in_valid;
	output logic                 in_stall;
	input  logic signed [SB-1:0] sample_value;
	input  logic                 block_end;
	input  logic                 q_full;
	output logic                 push;
	output logic [DESC_W-1:0]    push_data;
	output logic [WR_W-1:0]      wr;

	logic                   bank_q;
	logic [CW-1:0]          cnt_q;
	logic signed [SYW-1:0]  sy_q;
	logic signed [SXYW-1:0] sxy_q;
	logic [SXW-1:0]         sx_q;
	logic [SXXW-1:0]        sxx_q;

	logic                   take;
	logic                   room;
	logic signed [SB+CW:0]  wprod;
	logic [2*CW-1:0]        sq;
	desc_t                  nx;
	wr_t                    wr_c;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign room     = (cnt_q < CW'(DEPTH));
	assign wprod    = sample_value * $signed({1'b0, cnt_q});
	assign sq       = cnt_q * cnt_q;

	always_comb begin
		nx.bank = bank_q;
		nx.n    = cnt_q;
		nx.sy   = sy_q;
		nx.sxy  = sxy_q;
		nx.sx   = sx_q;
		nx.sxx  = sxx_q;
		if (room) begin
			nx.n   = cnt_q + CW'(1);
			nx.sy  = sy_q + {{(SYW-SB){sample_value[SB-1]}}, sample_value};
			nx.sxy = sxy_q + {{(SXYW-SB-CW-1){wprod[SB+CW]}}, wprod};
			nx.sx  = sx_q + {{(SXW-CW){1'b0}}, cnt_q};
			nx.sxx = sxx_q + {{CW{1'b0}}, sq};
		end
	end

	// store write goes to the bank the front currently owns
	always_comb begin
		wr_c.we   = take && room;
		wr_c.addr = {bank_q, cnt_q[XW-1:0]};
		wr_c.data = sample_value;
	end

	assign wr        = wr_c;
	assign push      = take && block_end;
	assign push_data = nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			cnt_q  <= '0;
			sy_q   <= '0;
			sxy_q  <= '0;
			sx_q   <= '0;
			sxx_q  <= '0;
		end else if (take) begin
			if (block_end) begin
				bank_q <= ~bank_q;
				cnt_q  <= '0;
				sy_q   <= '0;
				sxy_q  <= '0;
				sx_q   <= '0;
				sxx_q  <= '0;
			end else begin
				cnt_q <= nx.n;
				sy_q  <= nx.sy;
				sxy_q <= nx.sxy;
				sx_q  <= nx.sx;
				sxx_q <= nx.sxx;
			end
		end
	end

endmodule

FILE: sv/lfoc_back.sv
// lfoc_back: fits the line with a shared serial multiplier and divider, then emits results
// depends on lfoc_pkg; holds the two-bank sample store and the limit register
module lfoc_back #(
	parameter int DEPTH = 64
) (
	clk, arst_n, cfg_wr_en, cfg_wr_data, wr, q_not_empty, head, pop,
	out_valid, out_stall, point_index, is_inlier, abs_residual,
	fit_slope, fit_intercept, last_point
);
	localparam int SB     = lfoc_pkg::SAMPLE_BITS;
	localparam int FW     = lfoc_pkg::FIT_W;
	localparam int LW     = lfoc_pkg::LIMIT_W;
	localparam int QF     = lfoc_pkg::FRAC_BITS;
	localparam int IW     = lfoc_pkg::INDEX_W;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int XW     = $clog2(DEPTH);
	localparam int SYW    = SB + CW + 1;
	localparam int SXYW   = SB + 2 * CW + 1;
	localparam int SXW    = 2 * CW;
	localparam int SXXW   = 3 * CW;
	localparam int DESC_W = 1 + CW + SYW + SXYW + SXW + SXXW;
	localparam int WR_W   = 1 + XW + 1 + SB;
	localparam int OPW    = SB + 2 * CW + 2;
	localparam int AW     = 2 * OPW + 1;
	localparam int QW     = AW + QF;
	localparam int ITW    = $clog2(QW + 1);
	localparam int ACW    = FW + CW + 1;
	localparam int RW     = FW + CW + 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MLOAD = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_MFIN  = 4'd3;
	localparam logic [3:0] S_DLOAD = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_DFIN  = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_CALC  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	typedef struct packed {
		logic                   bank;
		logic [CW-1:0]          n;
		logic signed [SYW-1:0]  sy;
		logic signed [SXYW-1:0] sxy;
		logic [SXW-1:0]         sx;
		logic [SXXW-1:0]        sxx;
	} desc_t;

	typedef struct packed {
		logic          we;
		logic [XW:0]   addr;
		logic [SB-1:0] data;
	} wr_t;

	input  logic                 clk;
	input  logic                 arst_n;
	input  logic                 cfg_wr_en;
	input  logic [LW-1:0]        cfg_wr_data;
	input  logic [WR_W-1:0]      wr;
	input  logic                 q_not_empty;
	input  logic [DESC_W-1:0]    head;
	output logic                 pop;
	output logic                 out_valid;
	input  logic                 out_stall;
	output logic [IW-1:0]        point_index;
	output logic                 is_inlier;
	output logic [FW-1:0]        abs_residual;
	output logic signed [FW-1:0] fit_slope;
	output logic signed [FW-1:0] fit_intercept;
	output logic                 last_point;

	desc_t d;
	wr_t   wr_c;

	assign d    = head;
	assign wr_c = wr;

	// sample store, two banks
	logic [SB-1:0] mem [2**(XW+1)];
	logic [SB-1:0] rd_q;
	logic [XW:0]   rd_addr;

	logic [3:0]     state_q;
	logic [2:0]     step_q;
	logic           dsel_q;
	logic [ITW-1:0] it_q;
	logic [LW-1:0]  limit_q;

	logic [2*OPW-1:0]     ma_q;
	logic [OPW-1:0]       mb_q;
	logic [2*OPW-1:0]     macc_q;
	logic                 mneg_q;
	logic signed [AW-1:0] t1_q;
	logic signed [AW-1:0] ks_q;
	logic signed [AW-1:0] bs_q;
	logic [AW-1:0]        den_q;

	logic [QW-1:0] dvd_q;
	logic [AW:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic          dneg_q;

	logic signed [FW-1:0]  slope_q;
	logic signed [FW-1:0]  icpt_q;
	logic [CW-1:0]         i_q;
	logic signed [ACW-1:0] sacc_q;

	logic                 out_valid_q;
	logic [IW-1:0]        pidx_q;
	logic                 inlier_q;
	logic [FW-1:0]        ares_q;
	logic                 last_q;

	// multiplier operands
	logic signed [OPW-1:0] n_e, sx_e, sxx_e, sy_e, sxy_e;
	logic signed [OPW-1:0] op_a, op_b;
	logic [OPW-1:0]        abs_a, abs_b;
	logic [AW-1:0]         pm;
	logic signed [AW-1:0]  prod;

	assign n_e   = {{(OPW-CW){1'b0}}, d.n};
	assign sx_e  = {{(OPW-SXW){1'b0}}, d.sx};
	assign sxx_e = {{(OPW-SXXW){1'b0}}, d.sxx};
	assign sy_e  = {{(OPW-SYW){d.sy[SYW-1]}}, d.sy};
	assign sxy_e = {{(OPW-SXYW){d.sxy[SXYW-1]}}, d.sxy};

	// den = n*sxx - sx*sx, slope num = n*sxy - sx*sy, intercept num = sxx*sy - sx*sxy
	always_comb begin
		case (step_q)
			3'd0: begin op_a = n_e;   op_b = sxy_e; end
			3'd1: begin op_a = sx_e;  op_b = sy_e;  end
			3'd2: begin op_a = sxx_e; op_b = sy_e;  end
			3'd3: begin op_a = sx_e;  op_b = sxy_e; end
			3'd4: begin op_a = n_e;   op_b = sxx_e; end
			3'd5: begin op_a = sx_e;  op_b = sx_e;  end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign abs_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
	assign abs_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
	assign pm    = {1'b0, macc_q};
	assign prod  = mneg_q ? $signed(-pm) : $signed(pm);

	// divider step
	logic signed [AW-1:0] num;
	logic [AW-1:0]        num_mag;
	logic [AW:0]          rem2;
	logic                 ge;
	logic                 big;
	logic [FW-1:0]        qlo;
	logic [FW-1:0]        qsat;

	assign num     = dsel_q ? bs_q : ks_q;
	assign num_mag = num[AW-1] ? AW'(-num) : AW'(num);
	assign rem2    = {rem_q[AW-1:0], dvd_q[QW-1]};
	assign ge      = (rem2 >= {1'b0, den_q});
	assign big     = |quo_q[QW-1:FW-1];
	assign qlo     = quo_q[FW-1:0];
	assign qsat    = big ? (dneg_q ? lfoc_pkg::FIT_NEG_MIN : lfoc_pkg::FIT_POS_MAX)
	                     : (dneg_q ? FW'(-qlo) : qlo);

	// residual of the current point
	logic signed [RW-1:0] r_slope, r_icpt, r_y, resid;
	logic [RW-1:0]        r_mag;
	logic [CW:0]          i_next;
	logic [CW+IW-1:0]     idx_ext;

	assign r_slope = {{(RW-ACW){sacc_q[ACW-1]}}, sacc_q};
	assign r_icpt  = {{(RW-FW){icpt_q[FW-1]}}, icpt_q};
	assign r_y     = {{(RW-SB-QF){rd_q[SB-1]}}, rd_q, {QF{1'b0}}};
	assign resid   = r_slope + r_icpt - r_y;
	assign r_mag   = resid[RW-1] ? RW'(-resid) : RW'(resid);
	assign i_next  = {1'b0, i_q} + (CW+1)'(1);
	assign idx_ext = {{IW{1'b0}}, i_q};

	assign rd_addr = {d.bank, i_q[XW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_c.we) begin
			mem[wr_c.addr] <= wr_c.data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lfoc_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			dsel_q      <= 1'b0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
			slope_q     <= '0;
			icpt_q      <= '0;
			i_q         <= '0;
			sacc_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						i_q    <= '0;
						sacc_q <= '0;
						if (d.n == CW'(1)) begin
							// single sample: flat line through it
							slope_q <= '0;
							icpt_q  <= FW'({{FW{d.sy[SYW-1]}}, d.sy, {QF{1'b0}}});
							state_q <= S_RD;
						end else begin
							step_q  <= '0;
							state_q <= S_MLOAD;
						end
					end
				end
				S_MLOAD: begin
					ma_q    <= {{OPW{1'b0}}, abs_a};
					mb_q    <= abs_b;
					macc_q  <= '0;
					mneg_q  <= op_a[OPW-1] ^ op_b[OPW-1];
					it_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mb_q[0]) begin
						macc_q <= macc_q + ma_q;
					end
					ma_q <= {ma_q[2*OPW-2:0], 1'b0};
					mb_q <= {1'b0, mb_q[OPW-1:1]};
					it_q <= it_q + ITW'(1);
					if (it_q == ITW'(OPW - 1)) begin
						state_q <= S_MFIN;
					end
				end
				S_MFIN: begin
					if (!step_q[0]) begin
						t1_q <= prod;
					end else begin
						case (step_q[2:1])
							2'd0: ks_q <= t1_q - prod;
							2'd1: bs_q <= t1_q - prod;
							2'd2: den_q <= AW'(t1_q - prod);
							default: ks_q <= ks_q;
						endcase
					end
					if (step_q == 3'd5) begin
						dsel_q  <= 1'b0;
						state_q <= S_DLOAD;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_MLOAD;
					end
				end
				S_DLOAD: begin
					dneg_q  <= num[AW-1];
					dvd_q   <= {num_mag, {QF{1'b0}}};
					rem_q   <= '0;
					quo_q   <= '0;
					it_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? (rem2 - {1'b0, den_q}) : rem2;
					quo_q <= {quo_q[QW-2:0], ge};
					dvd_q <= {dvd_q[QW-2:0], 1'b0};
					it_q  <= it_q + ITW'(1);
					if (it_q == ITW'(QW - 1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					if (!dsel_q) begin
						slope_q <= qsat;
						dsel_q  <= 1'b1;
						state_q <= S_DLOAD;
					end else begin
						icpt_q  <= qsat;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					pidx_q      <= idx_ext[IW-1:0];
					inlier_q    <= (r_mag <= {{(RW-LW){1'b0}}, limit_q});
					ares_q      <= (|r_mag[RW-1:FW]) ? lfoc_pkg::RESID_MAX : r_mag[FW-1:0];
					last_q      <= (i_next == {1'b0, d.n});
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_next[CW-1:0];
							sacc_q  <= sacc_q + {{(ACW-FW){slope_q[FW-1]}}, slope_q};
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the bank is released once the last result of the block is taken
	assign pop           = (state_q == S_OUT) && !out_stall && last_q;
	assign out_valid     = out_valid_q;
	assign point_index   = pidx_q;
	assign is_inlier     = inlier_q;
	assign abs_residual  = ares_q;
	assign fit_slope     = slope_q;
	assign fit_intercept = icpt_q;
	assign last_point    = last_q;

endmodule

FILE: sv/line_fit_outlier_classifier.sv
// line_fit_outlier_classifier: samples stream in one per cycle into the free store bank; once
// one block is being fitted and the next has ended, input stalls until the older one is emitted.
// per block after block_end: the back picks it up, then runs six serial multiplies and
// two serial divides (a single sample skips the fit), then reads, computes and emits each result.
// reset clears counters, sums, queue and fit; the limit returns to 1.0; the store is not cleared.
// depends on lfoc_pkg, lfoc_front, lfoc_queue and lfoc_back
module line_fit_outlier_classifier #(
	parameter int DEPTH = 64
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cfg_wr_en,
	input  logic [lfoc_pkg::LIMIT_W-1:0]                   cfg_wr_data,
	input  logic                                           in_valid,
	output logic                                           in_stall,
	input  logic signed [lfoc_pkg::SAMPLE_BITS-1:0]        sample_value,
	input  logic                                           block_end,
	output logic                                           out_valid,
	input  logic                                           out_stall,
	output logic [lfoc_pkg::INDEX_W-1:0]                   point_index,
	output logic                                           is_inlier,
	output logic [lfoc_pkg::FIT_W-1:0]                     abs_residual,
	output logic signed [lfoc_pkg::FIT_W-1:0]              fit_slope,
	output logic signed [lfoc_pkg::FIT_W-1:0]              fit_intercept,
	output logic                                           last_point
);
	localparam int SB     = lfoc_pkg::SAMPLE_BITS;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int XW     = $clog2(DEPTH);
	localparam int DESC_W = 1 + CW + (SB + CW + 1) + (SB + 2 * CW + 1) + 2 * CW + 3 * CW;
	localparam int WR_W   = 1 + XW + 1 + SB;

	logic              q_full;
	logic              q_not_empty;
	logic              push;
	logic              pop;
	logic [DESC_W-1:0] push_data;
	logic [DESC_W-1:0] head;
	logic [WR_W-1:0]   wr;

	lfoc_front #(.DEPTH(DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_value(sample_value),
		.block_end   (block_end),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data),
		.wr          (wr)
	);

	lfoc_queue #(.W(DESC_W)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (head)
	);

	lfoc_back #(.DEPTH(DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.wr           (wr),
		.q_not_empty  (q_not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_index  (point_index),
		.is_inlier    (is_inlier),
		.abs_residual (abs_residual),
		.fit_slope    (fit_slope),
		.fit_intercept(fit_intercept),
		.last_point   (last_point)
	);

endmodule
